/* design/sdep_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdep_pkg
// Shared types and constants for the serial command framer.
// ----------------------------------------------------------------------------
package sdep_pkg;

    // result kinds
    localparam logic [2:0] KIND_SEND = 3'd0;
    localparam logic [2:0] KIND_POLL = 3'd1;
    localparam logic [2:0] KIND_CHAR = 3'd2;
    localparam logic [2:0] KIND_PKT  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;
    localparam logic [2:0] KIND_BUSY = 3'd5;

    // link bytes
    localparam logic [7:0] FRAME_START = 8'h10;
    localparam logic [7:0] RESP_START  = 8'h20;
    localparam logic [7:0] ERR_START   = 8'h80;
    localparam logic [7:0] DEF_BYTE    = 8'hFE;
    localparam logic [7:0] ORC_BYTE    = 8'hFF;

    localparam logic [15:0] CMD_ID_RESET = 16'h0A00;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       end_of_command;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] error_code;
        logic        length_error;
        logic        reply_complete;
        logic        last;
    } result_t;

    // results of one item, handed from the control stage to the output stage
    typedef struct packed {
        logic [1:0] res_cnt;
        logic       res0_ram;   // res0.out_byte comes from the chunk RAM
        result_t    res0;
        result_t    res1;
    } desc_t;

    function automatic result_t mk_result(input logic [2:0] kind);
        result_t r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/sdep_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdep_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* design/sdep_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdep_ctrl
// Framing/reply sequencer: updates state per input transfer, drives the chunk
// RAM and registers the results of the item for the output stage.
// ----------------------------------------------------------------------------
module sdep_ctrl
    import sdep_pkg::*;
#(
    parameter int MAX_CHUNK = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_data,
    input  wire logic [15:0]       command_id,
    // chunk RAM
    output logic                   ram_we,
    output logic [((MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1)-1:0] ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   ram_re,
    output logic [((MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1)-1:0] ram_raddr,
    // to output stage
    output logic                   d_valid,
    output desc_t                  d_desc,
    input  wire logic              d_take
);
    localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int CW = $clog2(MAX_CHUNK + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_CHUNK);

    localparam logic [2:0] PH_COLLECT   = 3'd0;
    localparam logic [2:0] PH_SEND_HEAD = 3'd1;
    localparam logic [2:0] PH_SEND_BODY = 3'd2;
    localparam logic [2:0] PH_HUNT      = 3'd3;
    localparam logic [2:0] PH_RESP_HEAD = 3'd4;
    localparam logic [2:0] PH_ERR_HEAD  = 3'd5;
    localparam logic [2:0] PH_PAYLOAD   = 3'd6;

    logic [2:0]    phase_reg,         phase_next;
    logic [CW-1:0] chunk_count_reg,   chunk_count_next;
    logic          chunk_more_reg,    chunk_more_next;
    logic [CW-1:0] send_index_reg,    send_index_next;
    logic [1:0]    header_count_reg,  header_count_next;
    logic [15:0]   reply_code_reg,    reply_code_next;
    logic [6:0]    reply_length_reg,  reply_length_next;
    logic          reply_more_reg,    reply_more_next;
    logic [6:0]    payload_count_reg, payload_count_next;
    logic          d_valid_reg,       d_valid_next;
    desc_t         desc_reg,          desc_next;

    logic          accept;
    logic [7:0]    b;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] idx_inc;
    logic [6:0]    pc_inc;
    logic [1:0]    n;
    logic          r0_ram;
    result_t       r0, r1;

    function automatic logic [7:0] header_byte(input logic [1:0] hc,
                                               input logic [15:0] id,
                                               input logic [CW-1:0] cnt,
                                               input logic more);
        logic [7:0] v;
        case (hc)
            2'd0:    v = FRAME_START;
            2'd1:    v = id[7:0];
            2'd2:    v = id[15:8];
            default: v = {more, 7'(cnt)};
        endcase
        return v;
    endfunction

    assign s_ready = !d_valid_reg || d_take;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign cnt_inc = chunk_count_reg + 1'b1;
    assign idx_inc = send_index_reg + 1'b1;
    assign pc_inc  = payload_count_reg + 7'd1;

    always_comb begin
        phase_next         = phase_reg;
        chunk_count_next   = chunk_count_reg;
        chunk_more_next    = chunk_more_reg;
        send_index_next    = send_index_reg;
        header_count_next  = header_count_reg;
        reply_code_next    = reply_code_reg;
        reply_length_next  = reply_length_reg;
        reply_more_next    = reply_more_reg;
        payload_count_next = payload_count_reg;
        n                  = 2'd0;
        r0_ram             = 1'b0;
        r0                 = mk_result(KIND_POLL);
        r1                 = mk_result(KIND_POLL);
        ram_we             = 1'b0;

        if (!s_data.action) begin
            if (phase_reg != PH_COLLECT) begin
                r0 = mk_result(KIND_BUSY);
                n  = 2'd1;
            end else begin
                ram_we           = accept;
                chunk_count_next = cnt_inc;
                if (s_data.end_of_command || cnt_inc >= MAX_C) begin
                    chunk_more_next   = !s_data.end_of_command;
                    phase_next        = PH_SEND_HEAD;
                    header_count_next = 2'd0;
                    r0                = mk_result(KIND_SEND);
                    r0.out_byte       = FRAME_START;
                    n                 = 2'd1;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_COLLECT: begin
                    n = 2'd0;
                end
                PH_SEND_HEAD: begin
                    r0 = mk_result(KIND_SEND);
                    n  = 2'd1;
                    if (b != DEF_BYTE && header_count_reg == 2'd3) begin
                        header_count_next = 2'd0;
                        phase_next        = PH_SEND_BODY;
                        send_index_next   = '0;
                        r0_ram            = 1'b1;
                    end else begin
                        if (b != DEF_BYTE) begin
                            header_count_next = header_count_reg + 2'd1;
                        end
                        r0.out_byte = header_byte(header_count_next, command_id,
                                                  chunk_count_reg, chunk_more_reg);
                    end
                end
                PH_SEND_BODY: begin
                    r0     = mk_result(KIND_SEND);
                    r0_ram = 1'b1;
                    n      = 2'd1;
                    if (b != DEF_BYTE) begin
                        if (idx_inc >= chunk_count_reg) begin
                            chunk_count_next = '0;
                            send_index_next  = '0;
                            r0_ram           = 1'b0;
                            if (chunk_more_reg) begin
                                chunk_more_next = 1'b0;
                                phase_next      = PH_COLLECT;
                                n               = 2'd0;
                            end else begin
                                phase_next = PH_HUNT;
                                r0         = mk_result(KIND_POLL);
                            end
                        end else begin
                            send_index_next = idx_inc;
                        end
                    end
                end
                PH_HUNT: begin
                    n = 2'd1;
                    if (b == RESP_START || b == ERR_START) begin
                        phase_next         = (b == ERR_START) ? PH_ERR_HEAD : PH_RESP_HEAD;
                        header_count_next  = 2'd0;
                        reply_code_next    = '0;
                        reply_length_next  = '0;
                        reply_more_next    = 1'b0;
                        payload_count_next = '0;
                    end
                end
                PH_RESP_HEAD: begin
                    n = 2'd1;
                    if (b == DEF_BYTE) begin
                        n = 2'd1;
                    end else if (b == ORC_BYTE) begin
                        reply_length_next = '0;
                        reply_more_next   = 1'b0;
                        r0                = mk_result(KIND_PKT);
                        r0.reply_complete = 1'b1;
                        phase_next        = PH_COLLECT;
                    end else if (header_count_reg == 2'd0) begin
                        reply_code_next   = {reply_code_reg[15:8], b};
                        header_count_next = 2'd1;
                    end else if (header_count_reg == 2'd1) begin
                        reply_code_next   = {b, reply_code_reg[7:0]};
                        header_count_next = 2'd2;
                    end else begin
                        reply_length_next  = b[6:0];
                        reply_more_next    = b[7];
                        header_count_next  = 2'd0;
                        payload_count_next = '0;
                        if (b[6:0] == 7'd0) begin
                            r0                = mk_result(KIND_PKT);
                            r0.reply_complete = !b[7];
                            phase_next        = b[7] ? PH_HUNT : PH_COLLECT;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_ERR_HEAD: begin
                    n = 2'd1;
                    if (b == DEF_BYTE) begin
                        n = 2'd1;
                    end else if (b == ORC_BYTE) begin
                        r0                = mk_result(KIND_ERR);
                        r0.error_code     = reply_code_reg;
                        r0.reply_complete = 1'b1;
                        phase_next        = PH_COLLECT;
                    end else if (header_count_reg == 2'd0) begin
                        reply_code_next   = {8'h00, b};
                        header_count_next = 2'd1;
                    end else begin
                        reply_code_next   = {b, reply_code_reg[7:0]};
                        header_count_next = 2'd0;
                        r0                = mk_result(KIND_ERR);
                        r0.error_code     = {b, reply_code_reg[7:0]};
                        r0.reply_complete = 1'b1;
                        phase_next        = PH_COLLECT;
                    end
                end
                PH_PAYLOAD: begin
                    n = 2'd1;
                    if (b == DEF_BYTE) begin
                        n = 2'd1;
                    end else if (b == ORC_BYTE) begin
                        r0                = mk_result(KIND_PKT);
                        r0.length_error   = 1'b1;
                        r0.reply_complete = !reply_more_reg;
                        phase_next        = reply_more_reg ? PH_HUNT : PH_COLLECT;
                    end else begin
                        n                  = 2'd2;
                        r0                 = mk_result(KIND_CHAR);
                        r0.out_byte        = b;
                        payload_count_next = pc_inc;
                        if (pc_inc >= reply_length_reg) begin
                            r1                = mk_result(KIND_PKT);
                            r1.reply_complete = !reply_more_reg;
                            phase_next        = reply_more_reg ? PH_HUNT : PH_COLLECT;
                        end
                    end
                end
                default: begin
                    n = 2'd0;
                end
            endcase
        end

        r0.last = (n == 2'd1);
        r1.last = 1'b1;

        desc_next.res_cnt  = n;
        desc_next.res0_ram = r0_ram;
        desc_next.res0     = r0;
        desc_next.res1     = r1;

        if (accept) begin
            d_valid_next = 1'b1;
        end else if (d_take) begin
            d_valid_next = 1'b0;
        end else begin
            d_valid_next = d_valid_reg;
        end
    end

    // chunk RAM: write while collecting, read the entry the next send needs
    assign ram_waddr = chunk_count_reg[AW-1:0];
    assign ram_wdata = b;
    assign ram_re    = accept;
    assign ram_raddr = send_index_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_COLLECT;
            chunk_count_reg   <= '0;
            chunk_more_reg    <= 1'b0;
            send_index_reg    <= '0;
            header_count_reg  <= '0;
            reply_code_reg    <= '0;
            reply_length_reg  <= '0;
            reply_more_reg    <= 1'b0;
            payload_count_reg <= '0;
            d_valid_reg       <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
            if (accept) begin
                phase_reg         <= phase_next;
                chunk_count_reg   <= chunk_count_next;
                chunk_more_reg    <= chunk_more_next;
                send_index_reg    <= send_index_next;
                header_count_reg  <= header_count_next;
                reply_code_reg    <= reply_code_next;
                reply_length_reg  <= reply_length_next;
                reply_more_reg    <= reply_more_next;
                payload_count_reg <= payload_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            desc_reg <= desc_next;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_desc  = desc_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_COLLECT |-> chunk_count_reg < MAX_C)
        else $error("chunk count reached limit while collecting");

    a_send_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SEND_BODY |-> send_index_reg < chunk_count_reg)
        else $error("send index beyond chunk");

    a_desc_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> d_valid_reg)
        else $error("accepted item lost before output stage");

endmodule
`default_nettype wire

/* design/sdep_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sdep_outq
// Output stage: holds up to two results of one item, merges RAM read data.
// ----------------------------------------------------------------------------
module sdep_outq
    import sdep_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       d_valid,
    input  wire desc_t      d_desc,
    output logic            d_take,
    input  wire logic [7:0] ram_rdata,
    output logic            m_valid,
    input  wire logic       m_ready,
    output result_t         m_data
);
    logic [1:0] cnt_reg, cnt_next;
    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;
    logic       pop;
    logic [1:0] rem;
    result_t    head;

    assign pop    = (cnt_reg != 2'd0) && m_ready;
    assign rem    = cnt_reg - {1'b0, pop};
    assign d_take = d_valid && (d_desc.res_cnt == 2'd0 || rem == 2'd0);

    always_comb begin
        head = d_desc.res0;
        if (d_desc.res0_ram) begin
            head.out_byte = ram_rdata;
        end
        cnt_next = rem;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        if (d_take && d_desc.res_cnt != 2'd0) begin
            cnt_next = d_desc.res_cnt;
            q0_next  = head;
            q1_next  = d_desc.res1;
        end else if (pop) begin
            q0_next = q1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q0_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output stage overfilled");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        d_take && d_desc.res_cnt != 2'd0 |=> cnt_reg == $past(d_desc.res_cnt))
        else $error("output stage load count mismatch");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        d_take && d_desc.res_cnt != 2'd0 |-> rem == 2'd0)
        else $error("results loaded over pending ones");

endmodule
`default_nettype wire

/* design/sdep_spi_command_framer.sv */
`default_nettype none
// Pipeline: the first result of an input transfer passes the control stage register,
//   then the output register, before it is presented. Throughput: one input per
//   cycle while each item gives at most one result and m_ready stays high; a
//   payload character followed by a poll or packet-done needs two output
//   transfers, set by the single output register pair.
// Reset: aresetn is synchronous, active low; phase returns to collecting, all
//   counters clear, command_id becomes 0x0A00. The chunk RAM is not cleared.
// ----------------------------------------------------------------------------
// sdep_spi_command_framer
// Frames host command bytes into chunks with a 4-byte header, resends on the
// link's default byte, then polls and parses the reply packets.
// ----------------------------------------------------------------------------
module sdep_spi_command_framer
    import sdep_pkg::*;
#(
    parameter int MAX_CHUNK = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items: host bytes or bytes received in the last link transfer
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_t         s_data,
    // result items
    output logic             m_valid,
    input  wire logic        m_ready,
    output result_t          m_data,
    // command_id register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

    logic [15:0]   command_id_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          d_valid;
    desc_t         d_desc;
    logic          d_take;

    // Register write is always taken; it lands in the header of the next
    // header byte computed, including a resend.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_id_reg <= CMD_ID_RESET;
        end else if (cfg_valid) begin
            command_id_reg <= cfg_data;
        end
    end

    // Chunk store: written one byte per host transfer, read one entry ahead
    // of the send stage so the data is ready when the output stage loads.
    sdep_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHUNK)
    ) u_chunk_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: all per-item state, one item per cycle unless the output stage holds s_ready low.
    sdep_ctrl #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .command_id (command_id_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .d_valid    (d_valid),
        .d_desc     (d_desc),
        .d_take     (d_take)
    );

    // Output register pair: decouples the result side from the input side.
    sdep_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .d_valid   (d_valid),
        .d_desc    (d_desc),
        .d_take    (d_take),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
